### rtl/dli_pkg.sv
// ----------------------------------------------------------------------------
// dli_pkg
// Shared field widths, beat layouts and the result record of the delta list
// insert block.
// ----------------------------------------------------------------------------
package dli_pkg;

  localparam int unsigned NODE_INDEX_W   = 4;
  localparam int unsigned DELAY_W        = 16;
  localparam int unsigned STORED_DELTA_W = 16;
  localparam int unsigned RANK_W         = 4;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef struct packed {
    logic                      at_tail;
    logic [RANK_W-1:0]         rank;
    logic [STORED_DELTA_W-1:0] stored_delta;
  } dli_result_t;

endpackage

### rtl/dli_ram.sv
// ----------------------------------------------------------------------------
// dli_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read. No reset of the contents.
// ----------------------------------------------------------------------------
module dli_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 26,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dli_ctrl.sv
// ----------------------------------------------------------------------------
// dli_ctrl
// Insert sequencer: walks the list through the node RAM one node per cycle,
// fetches the neighbor that gets relinked, then writes back the new node, the
// successor and the neighbor one entry per cycle.
// ----------------------------------------------------------------------------
module dli_ctrl
  import dli_pkg::*;
#(
  parameter int unsigned NODES       = 16,
  parameter int unsigned DELTA_WIDTH = 16,
  localparam int unsigned IW         = $clog2(NODES),
  localparam int unsigned LW         = $clog2(NODES + 1),
  localparam int unsigned CW         = $clog2(NODES + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  output logic                   req_ready_o,
  input  logic [IW-1:0]          req_node_i,
  input  logic [DELTA_WIDTH-1:0] req_rem_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output dli_result_t            res_o
);

  localparam logic [LW-1:0] LINK_NONE = LW'(NODES);
  localparam logic [CW-1:0] CNT_MAX   = CW'(NODES);

  typedef struct packed {
    logic [DELTA_WIDTH-1:0] delta;
    logic [LW-1:0]          nxt;
    logic [LW-1:0]          prv;
  } word_t;

  localparam int unsigned WW = $bits(word_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_LOAD,
    ST_WR_N,
    ST_WR_CUR,
    ST_WR_C,
    ST_DONE
  } state_e;

  function automatic logic [LW-1:0] link_of(input logic [LW-1:0] v);
    return (v < LINK_NONE) ? v : LINK_NONE;
  endfunction

  state_e                 state_q, state_d;
  logic [LW-1:0]          n_q, n_d;
  logic [DELTA_WIDTH-1:0] rem_q, rem_d;
  logic [CW-1:0]          steps_q, steps_d;
  logic [LW-1:0]          cur_q, cur_d;
  logic [LW-1:0]          c_q, c_d;
  logic                   ins_q, ins_d;
  word_t                  cur_word_q, cur_word_d;
  word_t                  c_word_q, c_word_d;
  logic [LW-1:0]          head_q, head_d;
  logic [LW-1:0]          tail_q, tail_d;
  logic [CW-1:0]          cnt_q, cnt_d;

  logic [IW-1:0] rd_addr;
  logic [WW-1:0] rd_data;
  word_t         rd_word;
  logic          we;
  logic [LW-1:0] upd_idx;
  word_t         upd_init;
  word_t         upd_word;
  logic [LW-1:0] nxt_link;
  logic [CW-1:0] steps_inc;
  logic [31:0]   rem_ext;
  logic [31:0]   steps_ext;

  dli_ram #(
    .DEPTH (NODES),
    .WIDTH (WW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (upd_idx[IW-1:0]),
    .wdata_i (upd_word),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign rd_word   = word_t'(rd_data);
  assign nxt_link  = link_of(rd_word.nxt);
  assign steps_inc = steps_q + CW'(1);

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    rem_d      = rem_q;
    steps_d    = steps_q;
    cur_d      = cur_q;
    c_d        = c_q;
    ins_d      = ins_q;
    cur_word_d = cur_word_q;
    c_word_d   = c_word_q;
    head_d     = head_q;
    tail_d     = tail_q;
    cnt_d      = cnt_q;
    rd_addr    = cur_q[IW-1:0];
    we         = 1'b0;
    upd_idx    = n_q;
    upd_init   = c_word_q;
    res_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          n_d     = LW'(req_node_i);
          rem_d   = req_rem_i;
          steps_d = '0;
          if (cnt_q == '0 || link_of(head_q) == LINK_NONE) begin
            ins_d   = 1'b0;
            c_d     = LINK_NONE;
            state_d = ST_LOAD;
          end else begin
            cur_d   = head_q;
            rd_addr = head_q[IW-1:0];
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (rem_q < rd_word.delta) begin
          ins_d      = 1'b1;
          cur_word_d = rd_word;
          c_d        = link_of(rd_word.prv);
          rd_addr    = c_d[IW-1:0];
          state_d    = ST_LOAD;
        end else begin
          rem_d   = rem_q - rd_word.delta;
          steps_d = steps_inc;
          if (steps_inc >= cnt_q || nxt_link == LINK_NONE) begin
            ins_d   = 1'b0;
            c_d     = link_of(tail_q);
            rd_addr = c_d[IW-1:0];
            state_d = ST_LOAD;
          end else begin
            cur_d   = nxt_link;
            rd_addr = nxt_link[IW-1:0];
          end
        end
      end
      ST_LOAD: begin
        c_word_d = rd_word;
        state_d  = ST_WR_N;
      end
      ST_WR_N: begin
        we      = 1'b1;
        upd_idx = n_q;
        state_d = ST_WR_CUR;
      end
      ST_WR_CUR: begin
        we       = ins_q;
        upd_idx  = cur_q;
        upd_init = cur_word_q;
        state_d  = ST_WR_C;
      end
      ST_WR_C: begin
        we      = (c_q != LINK_NONE);
        upd_idx = c_q;
        if (c_q == LINK_NONE) begin
          head_d = n_q;
        end
        if (!ins_q) begin
          tail_d = n_q;
        end
        if (cnt_q < CNT_MAX) begin
          cnt_d = cnt_q + CW'(1);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Apply the link updates in insert order to the entry being written back.
  always_comb begin
    upd_word = upd_init;
    if (ins_q) begin
      if (upd_idx == cur_q) begin
        upd_word.delta = cur_word_q.delta - rem_q;
      end
      if (upd_idx == n_q) begin
        upd_word.delta = rem_q;
        upd_word.prv   = c_q;
        upd_word.nxt   = cur_q;
      end
      if (upd_idx == cur_q) begin
        upd_word.prv = n_q;
      end
    end else begin
      if (upd_idx == n_q) begin
        upd_word.delta = rem_q;
        upd_word.prv   = c_q;
        upd_word.nxt   = LINK_NONE;
      end
    end
    if (upd_idx == c_q && c_q != LINK_NONE) begin
      upd_word.nxt = n_q;
    end
  end

  always_comb begin
    rem_ext            = 32'(rem_q);
    steps_ext          = 32'(steps_q);
    res_o.stored_delta = rem_ext[STORED_DELTA_W-1:0];
    res_o.rank         = steps_ext[RANK_W-1:0];
    res_o.at_tail      = ~ins_q;
  end

  assign req_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= LINK_NONE;
      tail_q  <= LINK_NONE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    rem_q      <= rem_d;
    steps_q    <= steps_d;
    cur_q      <= cur_d;
    c_q        <= c_d;
    ins_q      <= ins_d;
    cur_word_q <= cur_word_d;
    c_word_q   <= c_word_d;
  end

endmodule

### rtl/delta_list_insert_top.sv
// ----------------------------------------------------------------------------
// delta_list_insert_top
// Delta list insert over a fixed node pool held in one node RAM.
//
//   channel   dir   beat contents
//   s_axis    in    one insert request: node index and absolute delay
//   m_axis    out   one result: stored delta, rank, tail flag
//
// An insert walks at most NODES nodes (none for an empty list); the walk
// reads one RAM entry per cycle and the write-back stores up to three entries
// through the single write port.
// A result waits in the output register while the next request is taken.
// Reset clears the list to empty; the RAM contents need no clearing.
// ----------------------------------------------------------------------------
module delta_list_insert_top
  import dli_pkg::*;
#(
  parameter int unsigned NODES       = 16,
  parameter int unsigned DELTA_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [3:0] node_index, [19:4] delay, [23:20] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [15:0] stored_delta, [19:16] rank, [20] at_tail, [23:21] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned IW = $clog2(NODES);
  localparam logic [32:0] DELTA_MAX = (33'd1 << DELTA_WIDTH) - 33'd1;

  logic [NODE_INDEX_W-1:0] node_index;
  logic [DELAY_W-1:0]      delay;
  logic [8:0]              idx_red;
  logic [31:0]             delay_ext;
  logic [DELTA_WIDTH-1:0]  rem;
  logic                    res_valid;
  logic                    res_ready;
  dli_result_t             res;
  logic                    out_valid_q;
  dli_result_t             out_res_q;

  assign node_index = s_axis_tdata[NODE_INDEX_W-1:0];
  assign delay      = s_axis_tdata[NODE_INDEX_W +: DELAY_W];

  always_comb begin
    idx_red = 9'(node_index);
    for (int i = 0; i < 8; i++) begin
      if (idx_red >= 9'(NODES)) begin
        idx_red = idx_red - 9'(NODES);
      end
    end
  end

  always_comb begin
    delay_ext = 32'(delay);
    if (delay_ext > DELTA_MAX[31:0]) begin
      rem = DELTA_MAX[DELTA_WIDTH-1:0];
    end else begin
      rem = delay_ext[DELTA_WIDTH-1:0];
    end
  end

  dli_ctrl #(
    .NODES       (NODES),
    .DELTA_WIDTH (DELTA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_node_i  (idx_red[IW-1:0]),
    .req_rem_i   (rem),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = ~out_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_res_q);

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for delta_list_insert_top. A queue of insert requests
// feeds a clocked stream driver; a built-in delta list predictor computes the
// stored delta, rank and tail flag of every accepted beat, and a clocked
// monitor compares each result beat against the oldest prediction. Both
// stream sides idle at random in changing mixes, with one long receiver
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;
  import dli_pkg::*;

  localparam int unsigned NODE_CNT   = 16;
  localparam logic [4:0]  LINK_NONE  = 5'd16;
  localparam int unsigned LIMIT      = 200000;
  localparam int unsigned RAND_ITEMS = 500;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned DRAIN_CYC  = 40;

  typedef struct packed {
    logic [DELAY_W-1:0]      delay;
    logic [NODE_INDEX_W-1:0] node;
  } insert_req_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  insert_req_t pend_q[$];
  dli_result_t placement_q[$];

  logic [STORED_DELTA_W-1:0] delta_mem [NODE_CNT];
  logic [4:0]                next_mem  [NODE_CNT];
  logic [4:0]                prev_mem  [NODE_CNT];
  logic [4:0]                head_ptr  = LINK_NONE;
  logic [4:0]                tail_ptr  = LINK_NONE;
  logic [4:0]                entry_cnt = '0;

  int unsigned total_items = 0;
  int unsigned sent_cnt    = 0;
  int unsigned result_cnt  = 0;
  int unsigned tail_cnt    = 0;
  int unsigned err_cnt     = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned hold_at     = 0;
  int unsigned stall_left  = 0;
  logic        hold_done   = 1'b0;

  delta_list_insert_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [4:0] link_of(logic [4:0] v);
    return (v < NODE_CNT) ? v : LINK_NONE;
  endfunction

  function automatic dli_result_t insert_node(insert_req_t r);
    logic [4:0]                n;
    logic [4:0]                cur;
    logic [4:0]                p;
    logic [4:0]                t;
    logic [STORED_DELTA_W-1:0] remain;
    int unsigned               rank_cnt;
    int unsigned               steps;
    logic                      tail;
    dli_result_t               res;
    n        = {1'b0, r.node};
    remain   = r.delay;
    rank_cnt = 0;
    tail     = 1'b1;
    if (entry_cnt == 0 || link_of(head_ptr) == LINK_NONE) begin
      prev_mem[n[3:0]]  = LINK_NONE;
      next_mem[n[3:0]]  = LINK_NONE;
      head_ptr          = n;
      tail_ptr          = n;
      delta_mem[n[3:0]] = remain;
    end else begin
      cur = link_of(head_ptr);
      for (steps = 0; steps < entry_cnt && steps < NODE_CNT; steps++) begin
        if (cur == LINK_NONE) break;
        if (remain < delta_mem[cur[3:0]]) begin
          p                   = link_of(prev_mem[cur[3:0]]);
          delta_mem[cur[3:0]] = delta_mem[cur[3:0]] - remain;
          delta_mem[n[3:0]]   = remain;
          prev_mem[n[3:0]]    = p;
          next_mem[n[3:0]]    = cur;
          prev_mem[cur[3:0]]  = n;
          if (p == LINK_NONE) begin
            head_ptr = n;
          end else begin
            next_mem[p[3:0]] = n;
          end
          tail = 1'b0;
          break;
        end
        remain   = remain - delta_mem[cur[3:0]];
        rank_cnt = rank_cnt + 1;
        cur      = link_of(next_mem[cur[3:0]]);
      end
      if (tail) begin
        t                 = link_of(tail_ptr);
        delta_mem[n[3:0]] = remain;
        prev_mem[n[3:0]]  = t;
        next_mem[n[3:0]]  = LINK_NONE;
        if (t == LINK_NONE) begin
          head_ptr = n;
        end else begin
          next_mem[t[3:0]] = n;
        end
        tail_ptr = n;
      end
    end
    if (entry_cnt < NODE_CNT) entry_cnt = entry_cnt + 5'd1;
    res.stored_delta = delta_mem[n[3:0]];
    res.rank         = rank_cnt[RANK_W-1:0];
    res.at_tail      = tail;
    return res;
  endfunction

  function automatic int unsigned send_idle_pct();
    if (sent_cnt < total_items / 3) return 14;
    if (sent_cnt < 2 * total_items / 3) return 87;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (sent_cnt < total_items / 3) return 87;
    if (sent_cnt < 2 * total_items / 3) return 14;
    return 0;
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay();
    case ($urandom_range(4))
      0: return DELAY_W'($urandom_range(65535));
      1: return DELAY_W'($urandom_range(255));
      2: return DELAY_W'($urandom_range(4095));
      3: return DELAY_W'($urandom);
      default: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          2: return DELAY_W'(1);
          default: return DELAY_W'(65534);
        endcase
      end
    endcase
  endfunction

  task automatic push_req(int unsigned node, int unsigned delay);
    insert_req_t r;
    r.node  = NODE_INDEX_W'(node);
    r.delay = DELAY_W'(delay);
    pend_q.push_back(r);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        placement_q.push_back(insert_node(pend_q[0]));
        void'(pend_q.pop_front());
        sent_cnt <= sent_cnt + 1;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        s_axis_tvalid <= 1'b1;
      end else if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({pend_q[0].delay, pend_q[0].node});
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (!hold_done && sent_cnt >= hold_at) begin
      hold_done     <= 1'b1;
      stall_left    <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  always @(posedge clk_i) begin : check_blk
    dli_result_t got;
    dli_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(dli_result_t)-1:0];
      if (placement_q.size() == 0) begin
        $display("%0t: result beat expected none, actual %h", $time, got);
        err_cnt++;
      end else begin
        want = placement_q.pop_front();
        result_cnt++;
        if (want.at_tail) tail_cnt++;
        if (got.stored_delta !== want.stored_delta) begin
          $display("%0t: stored_delta expected %0d actual %0d",
                   $time, want.stored_delta, got.stored_delta);
          err_cnt++;
        end
        if (got.rank !== want.rank) begin
          $display("%0t: rank expected %0d actual %0d", $time, want.rank, got.rank);
          err_cnt++;
        end
        if (got.at_tail !== want.at_tail) begin
          $display("%0t: at_tail expected %0b actual %0b",
                   $time, want.at_tail, got.at_tail);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("delta_list_insert_top verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NODE_CNT; i++) begin
      delta_mem[i] = '0;
      next_mem[i]  = '0;
      prev_mem[i]  = '0;
    end
    push_req(5, 1000);
    push_req(0, 0);
    push_req(15, 65535);
    push_req(3, 1000);
    push_req(7, 500);
    push_req(9, 1);
    push_req(1, 65535);
    push_req(2, 1500);
    push_req(4, 0);
    push_req(6, 999);
    push_req(8, 1001);
    push_req(10, 2000);
    push_req(11, 32768);
    push_req(12, 65534);
    push_req(13, 7);
    push_req(14, 250);
    push_req(5, 0);
    push_req(0, 65535);
    push_req(15, 1000);
    push_req(3, 3000);
    push_req(7, 0);
    for (int i = 0; i < RAND_ITEMS; i++) begin
      push_req($urandom_range(NODE_CNT - 1), 32'(pick_delay()));
    end
    total_items = pend_q.size();
    hold_at     = 2 * total_items / 3 + 20;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pend_q.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (placement_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
    $display("%0d inserts checked: %0d appended at the tail, %0d linked ahead of a node,",
             result_cnt, tail_cnt, result_cnt - tail_cnt);
    $display("covering an empty list, a full pool, relinked nodes and a %0d-cycle output stall",
             HOLD_LEN);
    if (err_cnt == 0) begin
      $display("delta_list_insert_top verification clean");
    end else begin
      $display("delta_list_insert_top verification failed");
    end
    $finish;
  end

endmodule
